// ----- sv/fsed_pkg.sv -----
// Shared types and constants for the Floyd-Steinberg error diffusion core.
`timescale 1ns / 1ps
`default_nettype none

package fsed_pkg;

  // Field and datapath widths
  localparam int LINE_WIDTH_W = 13;
  localparam int PIXEL_W      = 8;
  localparam int ERR_W        = 12;  // diffused error, sixteenths
  localparam int DIFF_W       = 8;   // quantization error of one pixel
  localparam int SUM_W        = 14;  // pixel*16 plus incoming error

  localparam logic [LINE_WIDTH_W-1:0] LINE_WIDTH_RESET = 13'd512;

  // Levels of the quantizer
  localparam logic [PIXEL_W-1:0] LEVEL_MAX = 8'd255;

  // Diffusion weights in sixteenths
  localparam logic signed [ERR_W-1:0] WEIGHT_RIGHT      = 12'sd7;
  localparam logic signed [ERR_W-1:0] WEIGHT_BELOW      = 12'sd5;
  localparam logic signed [ERR_W-1:0] WEIGHT_BELOW_LEFT = 12'sd3;

  typedef logic signed [ERR_W-1:0]  err_t;
  typedef logic signed [DIFF_W-1:0] diff_t;
  typedef logic signed [SUM_W-1:0]  sum_t;

  // Per-pixel control flags from the column sequencer
  typedef struct packed {
    logic frame_start;
    logic first_row;
    logic last;
  } item_flags_t;

endpackage

`default_nettype wire

// ----- sv/floyd_steinberg_error_diffusion_core.sv -----
// Top level of the Floyd-Steinberg error diffusion halftoner.
//
// Takes 8-bit grey pixels in raster order and returns one binary halftone pixel for each,
// one pixel per clock while the result register is not held by out_stall: a new transaction is
// taken every cycle unless that register is stalled, and each result passes the input register,
// then the result register. The add, clamp and threshold loop that carries the right-hand error
// to the next pixel is combinational. Errors for the next row sit in a MAX_WIDTH-entry line store
// with one write and one read port; it needs no clearing after reset, since the first row of each
// image never reads it. Assert frame_start on the first pixel of each image. Change line_width only while idle.
`timescale 1ns / 1ps
`default_nettype none

module floyd_steinberg_error_diffusion_core #(
  parameter int MAX_WIDTH = 4096
) (
  input  wire                                 clk,
  input  wire                                 rst,
  input  wire                                 line_width_we,
  input  wire  [fsed_pkg::LINE_WIDTH_W-1:0]   line_width_data,
  input  wire                                 in_valid,
  output logic                                in_stall,
  input  wire  [fsed_pkg::PIXEL_W-1:0]        pixel,
  input  wire                                 frame_start,
  output logic                                out_valid,
  input  wire                                 out_stall,
  output logic                                halftone,
  output logic                                row_end
);

  localparam int AW = $clog2(MAX_WIDTH);

  logic [fsed_pkg::LINE_WIDTH_W-1:0] line_width;
  logic                              accept;
  logic [AW-1:0]                     item_col;
  fsed_pkg::item_flags_t             item_flags;
  fsed_pkg::err_t                    rd_data;
  logic                              wr_en;
  logic [AW-1:0]                     wr_addr;
  fsed_pkg::err_t                    wr_data;

  // Row width register
  always_ff @(posedge clk) begin
    if (rst) begin
      line_width <= fsed_pkg::LINE_WIDTH_RESET;
    end else if (line_width_we) begin
      line_width <= line_width_data;
    end
  end

  assign accept = in_valid && !in_stall;

  fsed_col_seq #(
    .MAX_WIDTH (MAX_WIDTH),
    .AW        (AW)
  ) u_col_seq (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .frame_start (frame_start),
    .line_width  (line_width),
    .col         (item_col),
    .flags       (item_flags)
  );

  fsed_line_buf #(
    .DEPTH (MAX_WIDTH),
    .AW    (AW)
  ) u_line_buf (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (accept),
    .rd_addr (item_col),
    .rd_data (rd_data)
  );

  fsed_diffuse #(
    .AW (AW)
  ) u_diffuse (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_pixel  (pixel),
    .in_col    (item_col),
    .in_flags  (item_flags),
    .rd_data   (rd_data),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .halftone  (halftone),
    .row_end   (row_end)
  );

endmodule

`default_nettype wire

// ----- sv/fsed_line_buf.sv -----
// Line store for errors diffused into the next row: one write port, one registered read port.
`timescale 1ns / 1ps
`default_nettype none

module fsed_line_buf #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12
) (
  input  wire                      clk,
  input  wire                      wr_en,
  input  wire  [AW-1:0]            wr_addr,
  input  wire  fsed_pkg::err_t     wr_data,
  input  wire                      rd_en,
  input  wire  [AW-1:0]            rd_addr,
  output fsed_pkg::err_t           rd_data
);

  fsed_pkg::err_t mem [DEPTH];

  // Write one entry
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read one entry, data registered
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ----- sv/fsed_col_seq.sv -----
// Column sequencer: column, first-row and row-end flags of each accepted pixel.
`timescale 1ns / 1ps
`default_nettype none

module fsed_col_seq #(
  parameter int MAX_WIDTH = 4096,
  parameter int AW        = 12
) (
  input  wire                                     clk,
  input  wire                                     rst,
  input  wire                                     accept,
  input  wire                                     frame_start,
  input  wire  [fsed_pkg::LINE_WIDTH_W-1:0]       line_width,
  output logic [AW-1:0]                           col,
  output fsed_pkg::item_flags_t                   flags
);

  localparam int CMPW = (AW + 1 > fsed_pkg::LINE_WIDTH_W) ? AW + 1 : fsed_pkg::LINE_WIDTH_W;

  logic [AW-1:0] front_col;
  logic [AW-1:0] front_col_next;
  logic          front_first;
  logic          front_first_next;
  logic [CMPW-1:0] col_inc;

  // Column and flags of the pixel now at the input
  always_comb begin
    col = frame_start ? '0 : front_col;
    flags.frame_start = frame_start;
    flags.first_row   = frame_start ? 1'b1 : front_first;
    col_inc = CMPW'({1'b0, col}) + CMPW'(1);
    // A zero width acts as one; widths beyond the store act as its depth
    flags.last = (col_inc >= CMPW'(line_width)) || (col == AW'(MAX_WIDTH - 1));
    front_col_next   = flags.last ? '0 : AW'(col_inc);
    front_first_next = flags.last ? 1'b0 : flags.first_row;
  end

  // Advance on each accepted transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      front_col   <= '0;
      front_first <= 1'b1;
    end else if (accept) begin
      front_col   <= front_col_next;
      front_first <= front_first_next;
    end
  end

endmodule

`default_nettype wire

// ----- sv/fsed_diffuse.sv -----
// Diffusion stage: input register, error add/clamp/threshold, spread, result register.
`timescale 1ns / 1ps
`default_nettype none

module fsed_diffuse #(
  parameter int AW = 12
) (
  input  wire                                 clk,
  input  wire                                 rst,
  input  wire                                 in_valid,
  output logic                                in_stall,
  input  wire  [fsed_pkg::PIXEL_W-1:0]        in_pixel,
  input  wire  [AW-1:0]                       in_col,
  input  wire  fsed_pkg::item_flags_t         in_flags,
  input  wire  fsed_pkg::err_t                rd_data,
  output logic                                wr_en,
  output logic [AW-1:0]                       wr_addr,
  output fsed_pkg::err_t                      wr_data,
  output logic                                out_valid,
  input  wire                                 out_stall,
  output logic                                halftone,
  output logic                                row_end
);

  // Input register
  logic                           s1_valid;
  logic [fsed_pkg::PIXEL_W-1:0]   s1_pixel;
  logic [AW-1:0]                  s1_col;
  fsed_pkg::item_flags_t          s1_flags;
  logic                           s1_byp_valid;
  fsed_pkg::err_t                 s1_byp_data;

  // Row state
  fsed_pkg::err_t right_error;
  fsed_pkg::err_t below_left_partial;
  fsed_pkg::err_t below_partial;

  // Last-column write waiting for a free write slot
  logic                   pend_valid;
  logic [AW-1:0]          pend_addr;
  fsed_pkg::err_t         pend_data;

  logic                   accept;
  logic                   s1_adv;
  logic                   w1_en;
  logic                   drain_en;
  fsed_pkg::err_t         line_err;
  fsed_pkg::err_t         right_eff;
  fsed_pkg::err_t         blp_eff;
  fsed_pkg::err_t         bp_eff;
  logic signed [fsed_pkg::ERR_W:0] total;
  fsed_pkg::sum_t         sum;
  logic [fsed_pkg::PIXEL_W-1:0] level;
  logic                   white;
  logic signed [fsed_pkg::PIXEL_W:0] diff_wide;
  fsed_pkg::diff_t        diff;
  fsed_pkg::err_t         diff_ext;
  fsed_pkg::err_t         below_left_done;
  fsed_pkg::err_t         blp_next;
  fsed_pkg::err_t         right_next;

  // Handshake
  always_comb begin
    s1_adv   = s1_valid && (!out_valid || !out_stall);
    in_stall = s1_valid && !s1_adv;
    accept   = in_valid && !in_stall;
  end

  // Quantize the pixel and split its error
  always_comb begin
    if (pend_valid && (pend_addr == s1_col)) begin
      line_err = pend_data;
    end else if (s1_byp_valid) begin
      line_err = s1_byp_data;
    end else begin
      line_err = rd_data;
    end
    right_eff = s1_flags.frame_start ? '0 : right_error;
    blp_eff   = s1_flags.frame_start ? '0 : below_left_partial;
    bp_eff    = s1_flags.frame_start ? '0 : below_partial;
    total = (fsed_pkg::ERR_W + 1)'(right_eff)
          + (s1_flags.first_row ? '0 : (fsed_pkg::ERR_W + 1)'(line_err));
    sum = $signed({2'b00, s1_pixel, 4'b0000}) + fsed_pkg::SUM_W'(total);
    // Saturate the whole level to 0..255
    if (sum[fsed_pkg::SUM_W-1]) begin
      level = '0;
    end else if (sum[fsed_pkg::SUM_W-2]) begin
      level = fsed_pkg::LEVEL_MAX;
    end else begin
      level = sum[11:4];
    end
    white     = level[fsed_pkg::PIXEL_W-1];
    diff_wide = $signed({1'b0, level})
              - $signed({1'b0, (white ? fsed_pkg::LEVEL_MAX : '0)});
    diff      = fsed_pkg::DIFF_W'(diff_wide);
    diff_ext  = fsed_pkg::ERR_W'(diff);
    below_left_done = blp_eff + diff_ext * fsed_pkg::WEIGHT_BELOW_LEFT;
    blp_next        = bp_eff + diff_ext * fsed_pkg::WEIGHT_BELOW;
    right_next      = diff_ext * fsed_pkg::WEIGHT_RIGHT;
  end

  // Line store write: finished left column first, pending last column otherwise
  always_comb begin
    w1_en    = s1_adv && (s1_col != '0);
    drain_en = pend_valid && !w1_en && !in_stall;
    wr_en    = w1_en || drain_en;
    wr_addr  = w1_en ? (s1_col - AW'(1)) : pend_addr;
    wr_data  = w1_en ? below_left_done : pend_data;
  end

  // Hold the input transaction and catch a same-cycle write to its column
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pixel     <= in_pixel;
      s1_col       <= in_col;
      s1_flags     <= in_flags;
      s1_byp_valid <= wr_en && (wr_addr == in_col);
      s1_byp_data  <= wr_data;
    end
  end

  // Advance row state; clear it at the end of a row
  always_ff @(posedge clk) begin
    if (rst) begin
      right_error        <= '0;
      below_left_partial <= '0;
      below_partial      <= '0;
    end else if (s1_adv) begin
      if (s1_flags.last) begin
        right_error        <= '0;
        below_left_partial <= '0;
        below_partial      <= '0;
      end else begin
        right_error        <= right_next;
        below_left_partial <= blp_next;
        below_partial      <= diff_ext;
      end
    end
  end

  // Park the last column of a row, drop it once written
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (s1_adv && s1_flags.last) begin
      pend_valid <= 1'b1;
    end else if (drain_en) begin
      pend_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_flags.last) begin
      pend_addr <= s1_col;
      pend_data <= blp_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      halftone <= white;
      row_end  <= s1_flags.last;
    end
  end

endmodule

`default_nettype wire

// ----- bench/floyd_steinberg_error_diffusion_core_test.sv -----
// Self-checking testbench for the Floyd-Steinberg error diffusion halftoning core.
`timescale 1ns / 1ps

module floyd_steinberg_error_diffusion_core_test;

  localparam int MAX_WIDTH    = 4096;
  localparam int QUIET_LIMIT  = 2000;  // cycles with no transaction on either side
  localparam int RANDOM_ITEMS = 400;
  localparam int SETTLE_GAP   = 4;     // pixel-to-result path: input register, then result register
  localparam int DRAIN_CYCLES = 8;
  localparam int HOLD_CYCLES  = 120;

  logic                              clk;
  logic                              rst;
  logic                              line_width_we;
  logic [fsed_pkg::LINE_WIDTH_W-1:0] line_width_data;
  logic                              in_valid;
  logic                              in_stall;
  logic [fsed_pkg::PIXEL_W-1:0]      pixel;
  logic                              frame_start;
  logic                              out_valid;
  logic                              out_stall;
  logic                              halftone;
  logic                              row_end;

  typedef struct packed {
    logic white;
    logic row_last;
  } dot_t;

  // Halftone predictor plus the queue of dots it still expects from the core
  class halftone_scoreboard;
    fsed_pkg::err_t                    line_err [MAX_WIDTH];
    bit                                line_written [MAX_WIDTH];
    fsed_pkg::err_t                    right_err;
    fsed_pkg::err_t                    below_left_sum;
    fsed_pkg::err_t                    below_sum;
    logic [fsed_pkg::ERR_W-1:0]        column;
    bit                                first_row;
    logic [fsed_pkg::LINE_WIDTH_W-1:0] width_reg;
    dot_t                              expected_dots [$];
    int                                errors;
    int                                pixels;
    int                                frames;
    int                                row_ends;
    int                                whites;

    function new();
      width_reg = fsed_pkg::LINE_WIDTH_RESET;
      first_row = 1'b1;
      clear_row();
      errors   = 0;
      pixels   = 0;
      frames   = 0;
      row_ends = 0;
      whites   = 0;
    endfunction

    function void clear_row();
      right_err      = '0;
      below_left_sum = '0;
      below_sum      = '0;
      column         = '0;
    endfunction

    function int active_width();
      if (width_reg == 0) return 1;
      if (width_reg > MAX_WIDTH) return MAX_WIDTH;
      return int'(width_reg);
    endfunction

    function void set_width(logic [fsed_pkg::LINE_WIDTH_W-1:0] w);
      width_reg = w;
    endfunction

    // A pixel outside the first row must not read a line entry nobody wrote
    function bit needs_frame_start();
      return !first_row && !line_written[column];
    endfunction

    function int pending();
      return expected_dots.size();
    endfunction

    // Advance the predictor by one accepted pixel transaction
    function void note_pixel(logic [fsed_pkg::PIXEL_W-1:0] p, logic fs);
      int   col;
      int   total;
      int   sum;
      int   level;
      int   quant_err;
      dot_t d;
      pixels++;
      if (fs) begin
        frames++;
        clear_row();
        first_row = 1'b1;
      end
      col        = int'(column);
      d.row_last = (col + 1 >= active_width());
      total      = int'(right_err);
      if (!first_row) total += int'(line_err[col]);
      sum = int'(p) * 16 + total;
      if (sum < 0) level = 0;
      else level = sum / 16;
      if (level > 255) level = 255;
      d.white   = (level >= 128);
      quant_err = d.white ? level - 255 : level;
      // Spread the error: below-left completes, below and right carry forward
      if (col >= 1) begin
        line_err[col-1]     = fsed_pkg::err_t'(below_left_sum
                              + fsed_pkg::WEIGHT_BELOW_LEFT * quant_err);
        line_written[col-1] = 1'b1;
      end
      below_left_sum = fsed_pkg::err_t'(below_sum + fsed_pkg::WEIGHT_BELOW * quant_err);
      below_sum      = fsed_pkg::err_t'(quant_err);
      right_err      = fsed_pkg::err_t'(fsed_pkg::WEIGHT_RIGHT * quant_err);
      if (d.row_last) begin
        line_err[col]     = below_left_sum;
        line_written[col] = 1'b1;
        clear_row();
        first_row = 1'b0;
      end else begin
        column = fsed_pkg::ERR_W'(col + 1);
      end
      expected_dots = {expected_dots, d};
    endfunction

    // Compare one accepted result transaction with the oldest expectation
    function void check_dot(logic h, logic re);
      dot_t d;
      if (expected_dots.size() == 0) begin
        $error("unexpected result: halftone=%0b row_end=%0b with no pixel pending", h, re);
        errors++;
        return;
      end
      d = expected_dots.pop_front();
      row_ends += d.row_last;
      whites   += d.white;
      if (h !== d.white) begin
        $error("halftone: expected %0b, got %0b", d.white, h);
        errors++;
      end
      if (re !== d.row_last) begin
        $error("row_end: expected %0b, got %0b", d.row_last, re);
        errors++;
      end
    endfunction
  endclass

  halftone_scoreboard sb;
  int tx_idle_max;
  int rx_idle_max;
  int rx_hold_cycles;
  int quiet_cycles = 0;
  bit watch_on = 1'b0;

  floyd_steinberg_error_diffusion_core #(
    .MAX_WIDTH(MAX_WIDTH)
  ) dut (
    .clk(clk),
    .rst(rst),
    .line_width_we(line_width_we),
    .line_width_data(line_width_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .pixel(pixel),
    .frame_start(frame_start),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .halftone(halftone),
    .row_end(row_end)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Result side: stall a random number of cycles, or the requested hold, before each transaction
  initial begin : result_sink
    int wait_cycles;
    out_stall <= 1'b0;
    wait (rst === 1'b0);
    forever begin
      if (rx_hold_cycles > 0) begin
        wait_cycles    = rx_hold_cycles;
        rx_hold_cycles = 0;
      end else begin
        wait_cycles = $urandom_range(0, rx_idle_max);
      end
      if (wait_cycles > 0) begin
        out_stall <= 1'b1;
        repeat (wait_cycles) @(posedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (!(out_valid === 1'b1 && out_stall === 1'b0));
    end
  end

  // Check every accepted result
  always @(posedge clk) begin
    if (rst === 1'b0 && out_valid === 1'b1 && out_stall === 1'b0) begin
      sb.check_dot(halftone, row_end);
    end
  end

  // End the run when nothing moves for too long
  always @(posedge clk) begin
    if (watch_on) begin
      if ((in_valid === 1'b1 && in_stall === 1'b0) ||
          (out_valid === 1'b1 && out_stall === 1'b0)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("timeout: no transaction for %0d cycles", QUIET_LIMIT);
        $display("floyd_steinberg_error_diffusion_core_test: errors");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Offer one pixel, hold it until accepted, then idle a random gap
  task automatic send_pixel(input logic [fsed_pkg::PIXEL_W-1:0] p, input logic fs);
    int gap;
    in_valid    <= 1'b1;
    pixel       <= p;
    frame_start <= fs;
    do @(posedge clk); while (in_stall !== 1'b0);
    sb.note_pixel(p, fs);
    gap = $urandom_range(0, tx_idle_max);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Drop valid and wait until every expected dot has come back
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_GAP) @(posedge clk);
  endtask

  task automatic write_width(input logic [fsed_pkg::LINE_WIDTH_W-1:0] w);
    line_width_we   <= 1'b1;
    line_width_data <= w;
    @(posedge clk);
    line_width_we <= 1'b0;
    sb.set_width(w);
  endtask

  // Favor the quantizer edges and flat runs, which stress saturation
  function automatic logic [fsed_pkg::PIXEL_W-1:0] pick_pixel(
    logic [fsed_pkg::PIXEL_W-1:0] prev
  );
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return fsed_pkg::LEVEL_MAX;
      2:       return 8'd127;
      3:       return 8'd128;
      4, 5:    return prev;
      default: return fsed_pkg::PIXEL_W'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic run_phase(input int count, input bit new_frame, input bit pause_midway);
    logic                         fs;
    logic [fsed_pkg::PIXEL_W-1:0] p;
    p = fsed_pkg::PIXEL_W'($urandom_range(0, 255));
    for (int i = 0; i < count; i++) begin
      // Hold the sender until the core has drained completely
      if (pause_midway && i == count / 2) begin
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0) @(posedge clk);
      end
      fs = (i == 0 && new_frame) || ($urandom_range(0, 49) == 0) || sb.needs_frame_start();
      p  = pick_pixel(p);
      send_pixel(p, fs);
    end
  endtask

  initial begin : stimulus
    int random_items;
    int phase;
    int count;
    int w;
    bit new_frame;
    sb = new();
    rst             <= 1'b1;
    line_width_we   <= 1'b0;
    line_width_data <= '0;
    in_valid        <= 1'b0;
    pixel           <= '0;
    frame_start     <= 1'b0;
    tx_idle_max    = 15;
    rx_idle_max    = 15;
    rx_hold_cycles = 0;
    repeat (5) @(posedge clk);
    rst      <= 1'b0;
    watch_on <= 1'b1;
    @(posedge clk);

    // Reset width: black/white extremes, clamp high after 127, clamp low after 200
    send_pixel(8'd0, 1'b1);
    send_pixel(fsed_pkg::LEVEL_MAX, 1'b0);
    send_pixel(8'd127, 1'b0);
    send_pixel(fsed_pkg::LEVEL_MAX, 1'b0);
    send_pixel(8'd200, 1'b0);
    send_pixel(8'd0, 1'b0);
    settle();

    // Shrink mid-row: the next pixel is past the new last column and ends the row
    write_width(13'd3);
    send_pixel(8'd128, 1'b0);
    send_pixel(8'd64, 1'b0);
    send_pixel(8'd192, 1'b0);
    send_pixel(8'd32, 1'b0);
    send_pixel(fsed_pkg::LEVEL_MAX, 1'b0);
    send_pixel(8'd0, 1'b0);
    send_pixel(8'd16, 1'b0);
    send_pixel(8'd240, 1'b0);
    settle();

    // Zero width acts as one pixel per row
    write_width(13'd0);
    send_pixel(8'd128, 1'b0);
    send_pixel(8'd127, 1'b0);
    send_pixel(fsed_pkg::LEVEL_MAX, 1'b0);
    send_pixel(8'd0, 1'b0);
    send_pixel(fsed_pkg::LEVEL_MAX, 1'b1);
    settle();

    // Oversized width clamps to the line store depth
    write_width(13'h1FFF);
    send_pixel(8'd90, 1'b0);
    send_pixel(8'd160, 1'b0);
    send_pixel(8'd10, 1'b0);

    // Random phases: new widths, frames that carry on across width changes
    random_items = 0;
    phase        = 0;
    while (random_items < RANDOM_ITEMS) begin
      settle();
      if ($urandom_range(0, 3) != 0) begin
        case ($urandom_range(0, 9))
          0:       w = 0;
          1:       w = $urandom_range(MAX_WIDTH, 8191);
          2:       w = MAX_WIDTH;
          3:       w = $urandom_range(13, 80);
          default: w = $urandom_range(1, 12);
        endcase
        write_width(w[fsed_pkg::LINE_WIDTH_W-1:0]);
      end
      tx_idle_max = ($urandom_range(0, 3) == 0) ? 0 : 15;
      rx_idle_max = ($urandom_range(0, 3) == 0) ? 0 : 15;
      count       = $urandom_range(15, 50);
      new_frame   = 1'($urandom_range(0, 1));
      // Back up the core: long receiver hold while the sender streams
      if (phase == 1) begin
        tx_idle_max    = 0;
        rx_hold_cycles = HOLD_CYCLES;
      end
      run_phase(count, new_frame, phase == 3);
      random_items += count;
      phase++;
    end

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Covered %0d pixels, %0d frame starts, %0d row ends, %0d white dots.",
             sb.pixels, sb.frames, sb.row_ends, sb.whites);
    $display("Widths from zero through oversize, mid-row shrinks, stalls on both sides.");
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("floyd_steinberg_error_diffusion_core_test: clean");
    end else begin
      $display("floyd_steinberg_error_diffusion_core_test: errors");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
sv/fsed_pkg.sv
sv/fsed_line_buf.sv
sv/fsed_col_seq.sv
sv/fsed_diffuse.sv
sv/floyd_steinberg_error_diffusion_core.sv
bench/floyd_steinberg_error_diffusion_core_test.sv
